// ----- src/rfcm_pkg.sv -----
package rfcm_pkg;

  // Field widths of the frame and result transactions.
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned FAULT_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SAFE_STATE  = 3'd0,
    CFG_MAX_SPEED_STATE = 3'd1,
    CFG_TIMEOUT_LIMIT   = 3'd2,
    CFG_INVALID_LIMIT   = 3'd3,
    CFG_STALE_LIMIT     = 3'd4
  } cfg_index_t;

  // Reported fault causes.
  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_TIMEOUT = 2'd1,
    FAULT_INVALID = 2'd2,
    FAULT_STALE   = 2'd3
  } fault_cause_t;

endpackage

// ----- src/rfcm_ifs.sv -----
// Frame transaction channel: one polling tick of the mailbox.
interface rfcm_in_if import rfcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_present;
  logic [SEQ_W-1:0]  frame_seq;
  logic [BYTE_W-1:0] frame_byte0;
  logic [BYTE_W-1:0] frame_byte1;
  logic [BYTE_W-1:0] frame_byte2;

  modport source (output valid, frame_present, frame_seq, frame_byte0, frame_byte1,
                  frame_byte2, input ready);
  modport sink (input valid, frame_present, frame_seq, frame_byte0, frame_byte1,
                frame_byte2, output ready);
endinterface

// Result transaction channel: decoded signals and fault cause.
interface rfcm_out_if import rfcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               signals_applied;
  logic [NIB_W-1:0]   safety_state;
  logic [NIB_W-1:0]   speed_state;
  logic               brake_flag;
  logic [NIB_W-1:0]   event_state;
  logic               ack_button;
  logic [FAULT_W-1:0] fault_cause;
  logic               ack_changed;

  modport source (output valid, signals_applied, safety_state, speed_state, brake_flag,
                  event_state, ack_button, fault_cause, ack_changed, input ready);
  modport sink (input valid, signals_applied, safety_state, speed_state, brake_flag,
                event_state, ack_button, fault_cause, ack_changed, output ready);
endinterface

// Configuration write channel.
interface rfcm_cfg_if import rfcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rx_frame_comm_monitor.sv -----
// Receive-frame communication monitor.
// The frame channel carries one mailbox poll per transaction: a present flag,
// the writer's sequence number and three packed frame bytes. Every frame
// transaction produces exactly one result transaction carrying the decoded
// signals (only when signals_applied is set) and the fault cause.
// The cfg channel writes the five limit registers by index; it is always
// ready and is meant to be used while no frame transactions are in flight.
// A transaction lands in the input register, is then evaluated against the
// monitor state, and its result is loaded into the result register.
// Throughput is one transaction per cycle while the result receiver does not
// stall, bounded by the single state update between those two registers.
// Reset clears the sequence, counters and alive/ack tracking, empties both
// registers and sets every limit register to 3.
// When the result receiver stalls, the result register holds its transaction
// and the input register can still take one more; ready on the frame channel
// drops only once both are full.
module rx_frame_comm_monitor import rfcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rfcm_cfg_if.sink   cfg,
  rfcm_in_if.sink    frame,
  rfcm_out_if.source result
);

  typedef struct packed {
    logic              frame_present;
    logic [SEQ_W-1:0]  frame_seq;
    logic [BYTE_W-1:0] frame_byte0;
    logic [BYTE_W-1:0] frame_byte1;
    logic [BYTE_W-1:0] frame_byte2;
  } frame_t;

  typedef struct packed {
    logic               signals_applied;
    logic [NIB_W-1:0]   safety_state;
    logic [NIB_W-1:0]   speed_state;
    logic               brake_flag;
    logic [NIB_W-1:0]   event_state;
    logic               ack_button;
    logic [FAULT_W-1:0] fault_cause;
    logic               ack_changed;
  } result_t;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  // Configuration registers.
  logic [NIB_W-1:0] max_safe_state;
  logic [NIB_W-1:0] max_speed_state;
  logic [CNT_W-1:0] timeout_limit;
  logic [CNT_W-1:0] invalid_limit;
  logic [CNT_W-1:0] stale_limit;

  // Monitor state and its next values.
  logic [SEQ_W-1:0] last_seq, last_seq_next;
  logic [CNT_W-1:0] no_frame_count, no_frame_count_next;
  logic [CNT_W-1:0] invalid_count, invalid_count_next;
  logic [NIB_W-1:0] prev_alive, prev_alive_next;
  logic             alive_seen, alive_seen_next;
  logic [CNT_W-1:0] stale_count, stale_count_next;
  logic [NIB_W-1:0] prev_ack_seq, prev_ack_seq_next;
  logic             ack_seen, ack_seen_next;

  // Pipeline registers.
  logic    in_valid;
  frame_t  in_frame;
  logic    out_valid;
  result_t out_result;
  result_t result_next;

  logic advance;
  logic out_free;

  // Decoded frame fields.
  logic [NIB_W-1:0] dec_safe, dec_speed, dec_event, dec_alive, dec_ack_seq;
  logic             dec_brake, dec_ack_button, dec_valid, dec_reserved;
  logic             frame_bad;

  assign cfg.ready   = 1'b1;
  assign out_free    = !out_valid || result.ready;
  assign advance     = in_valid && out_free;
  assign frame.ready = !in_valid || out_free;

  assign dec_safe       = in_frame.frame_byte0[3:0];
  assign dec_speed      = in_frame.frame_byte0[7:4];
  assign dec_brake      = in_frame.frame_byte1[0];
  assign dec_event      = in_frame.frame_byte1[4:1];
  assign dec_ack_button = in_frame.frame_byte1[5];
  assign dec_valid      = in_frame.frame_byte1[6];
  assign dec_reserved   = in_frame.frame_byte1[7];
  assign dec_alive      = in_frame.frame_byte2[3:0];
  assign dec_ack_seq    = in_frame.frame_byte2[7:4];
  assign frame_bad      = !dec_valid || dec_reserved || (dec_safe > max_safe_state) ||
                          (dec_speed > max_speed_state);

  // Evaluate the registered frame against the monitor state.
  always_comb begin
    last_seq_next       = last_seq;
    no_frame_count_next = no_frame_count;
    invalid_count_next  = invalid_count;
    prev_alive_next     = prev_alive;
    alive_seen_next     = alive_seen;
    stale_count_next    = stale_count;
    prev_ack_seq_next   = prev_ack_seq;
    ack_seen_next       = ack_seen;
    result_next         = '0;

    if (in_frame.frame_present) begin
      if (in_frame.frame_seq == last_seq) begin
        // Repeated sequence number: no new frame this tick.
        no_frame_count_next = sat_inc(no_frame_count);
        if (no_frame_count_next >= timeout_limit) begin
          result_next.fault_cause = FAULT_TIMEOUT;
        end
      end else begin
        last_seq_next       = in_frame.frame_seq;
        no_frame_count_next = '0;
        if (frame_bad) begin
          invalid_count_next = sat_inc(invalid_count);
          if (invalid_count_next >= invalid_limit) begin
            result_next.fault_cause = FAULT_INVALID;
          end
        end else begin
          invalid_count_next = '0;
          // Alive counter tracking; the first good frame only records it.
          if (!alive_seen) begin
            alive_seen_next  = 1'b1;
            stale_count_next = '0;
          end else if (dec_alive == prev_alive) begin
            stale_count_next = sat_inc(stale_count);
          end else begin
            stale_count_next = '0;
          end
          prev_alive_next = dec_alive;

          if (stale_count_next >= stale_limit) begin
            result_next.fault_cause = FAULT_STALE;
          end else begin
            result_next.signals_applied = 1'b1;
            result_next.safety_state    = dec_safe;
            result_next.speed_state     = dec_speed;
            result_next.brake_flag      = dec_brake;
            result_next.event_state     = dec_event;
            result_next.ack_button      = dec_ack_button;
            // Acknowledge sequence change; the first applied frame only records it.
            if (!ack_seen) begin
              ack_seen_next = 1'b1;
            end else begin
              result_next.ack_changed = (dec_ack_seq != prev_ack_seq);
            end
            prev_ack_seq_next = dec_ack_seq;
          end
        end
      end
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_safe_state  <= NIB_W'(3);
      max_speed_state <= NIB_W'(3);
      timeout_limit   <= CNT_W'(3);
      invalid_limit   <= CNT_W'(3);
      stale_limit     <= CNT_W'(3);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAX_SAFE_STATE:  max_safe_state  <= cfg.data[NIB_W-1:0];
        CFG_MAX_SPEED_STATE: max_speed_state <= cfg.data[NIB_W-1:0];
        CFG_TIMEOUT_LIMIT:   timeout_limit   <= cfg.data;
        CFG_INVALID_LIMIT:   invalid_limit   <= cfg.data;
        CFG_STALE_LIMIT:     stale_limit     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Monitor state advances when the registered frame moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq       <= '0;
      no_frame_count <= '0;
      invalid_count  <= '0;
      prev_alive     <= '0;
      alive_seen     <= 1'b0;
      stale_count    <= '0;
      prev_ack_seq   <= '0;
      ack_seen       <= 1'b0;
    end else if (advance) begin
      last_seq       <= last_seq_next;
      no_frame_count <= no_frame_count_next;
      invalid_count  <= invalid_count_next;
      prev_alive     <= prev_alive_next;
      alive_seen     <= alive_seen_next;
      stale_count    <= stale_count_next;
      prev_ack_seq   <= prev_ack_seq_next;
      ack_seen       <= ack_seen_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_frame.frame_present <= frame.frame_present;
      in_frame.frame_seq     <= frame.frame_seq;
      in_frame.frame_byte0   <= frame.frame_byte0;
      in_frame.frame_byte1   <= frame.frame_byte1;
      in_frame.frame_byte2   <= frame.frame_byte2;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.signals_applied = out_result.signals_applied;
  assign result.safety_state    = out_result.safety_state;
  assign result.speed_state     = out_result.speed_state;
  assign result.brake_flag      = out_result.brake_flag;
  assign result.event_state     = out_result.event_state;
  assign result.ack_button      = out_result.ack_button;
  assign result.fault_cause     = out_result.fault_cause;
  assign result.ack_changed     = out_result.ack_changed;

endmodule
